/* rtl/core/tsfd_pkg.sv */
// Shared types, codes and constants for the treadmill status frame decoder.
// Holds the speed interpolation table and the saturating total update helpers.
// No dependencies.
`default_nettype none
package tsfd_pkg;

    localparam int CAPTURE_DEPTH = 17;
    localparam int SPEED_STEP_MAX = 80;
    localparam int SPEED_BASE_ENTRIES = 16;

    localparam int IDX_ELAPSED_SEC = 3;
    localparam int IDX_ELAPSED_MIN = 4;
    localparam int IDX_DIST_HI = 5;
    localparam int IDX_DIST_LO = 6;
    localparam int IDX_CAL_HI = 7;
    localparam int IDX_CAL_LO = 8;
    localparam int IDX_SPEED = 10;
    localparam int IDX_STEPS_HI = 12;
    localparam int IDX_STEPS_LO = 13;
    localparam int IDX_STATUS = 14;
    localparam int IDX_COUNTDOWN = 16;

    localparam logic [23:0] MS_PER_SEC = 24'd1000;
    localparam logic [23:0] MS_PER_MIN = 24'd60000;
    localparam logic [14:0] HI_BYTE_SCALE = 15'd100;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [7:0] STATUS_STOPPED = 8'd1;
    localparam logic [7:0] STATUS_STARTING = 8'd2;
    localparam logic [7:0] STATUS_RUNNING = 8'd3;
    localparam logic [7:0] STATUS_PAUSED = 8'd4;

    typedef enum logic [2:0] {
        DEV_STOPPED,
        DEV_STARTING,
        DEV_RUNNING,
        DEV_PAUSED,
        DEV_UNKNOWN
    } dev_state_t;

    typedef logic [7:0] frame_bytes_t [CAPTURE_DEPTH];
    typedef logic [9:0] speed_lut_t [SPEED_STEP_MAX + 1];

    typedef struct packed {
        dev_state_t  state;
        logic [7:0]  countdown;
        logic [23:0] elapsed;
        logic [14:0] distance;
        logic [14:0] calories;
        logic [6:0]  speed_step;
        logic [9:0]  real_speed;
        logic [14:0] steps;
    } decode_t;

    localparam int SPEED_BASE [SPEED_BASE_ENTRIES] = '{
        0, 70, 150, 240, 330, 430, 520, 610, 710,
        710, 710, 710, 710, 710, 710, 710
    };

    function automatic speed_lut_t build_speed_lut(input int entries);
        int last;
        int lo;
        int hi;
        int frac;
        int lo_v;
        int hi_v;
        int r;
        speed_lut_t lut;
        last = entries - 1;
        if (last > SPEED_BASE_ENTRIES - 1)
        begin
            last = SPEED_BASE_ENTRIES - 1;
        end
        for (int s = 0; s <= SPEED_STEP_MAX; s++)
        begin
            lo = s / 10;
            hi = (s + 9) / 10;
            frac = s - lo * 10;
            if (lo > last)
            begin
                lo = last;
            end
            if (hi > last)
            begin
                hi = last;
            end
            lo_v = SPEED_BASE[lo];
            hi_v = SPEED_BASE[hi];
            if (hi_v >= lo_v)
            begin
                r = lo_v + ((hi_v - lo_v) * frac) / 10;
            end
            else
            begin
                r = lo_v - ((lo_v - hi_v) * frac) / 10;
            end
            if (r > 1023)
            begin
                r = 1023;
            end
            lut[s] = 10'(r);
        end
        return lut;
    endfunction

    function automatic logic [31:0] track32(input logic [31:0] now, input logic [31:0] prev,
                                            input logic [31:0] sum);
        logic [32:0] s;
        s = {1'b0, sum} + {1'b0, now - prev};
        if (now > prev)
        begin
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        end
        return sum;
    endfunction

    function automatic logic [15:0] track16(input logic [15:0] now, input logic [15:0] prev,
                                            input logic [15:0] sum);
        logic [16:0] s;
        s = {1'b0, sum} + {1'b0, now - prev};
        if (now > prev)
        begin
            return s[16] ? 16'hFFFF : s[15:0];
        end
        return sum;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/treadmill_status_frame_decoder_unit.sv */
// Treadmill status frame decoder: input word register, frame capture, decode and totals.
// Depends on tsfd_pkg and tsfd_decode.
//
// Input channel (in_valid / in_stall): one word per cycle while in_stall is low,
// either a frame byte (req_type = 0, frame_end marks the last byte) or a clear
// request (req_type = 1) that loads the totals with the current session values.
// Output channel (out_valid / out_stall): one result word per frame end or clear
// request; plain frame bytes give none. The result fields are the decoded session
// values, the speed, the four totals and the short-frame flag.
// Throughput: one input word per cycle while in_stall is low; the decode and total
// update take a single pass between the input register and the result registers.
// While the receiver stalls, the result holds; frame bytes keep flowing, and
// in_stall rises only when a frame end or clear request is waiting behind an
// untaken result.
// Reset clears the byte position, the stored session values and the totals;
// captured bytes are not cleared, they are always written before use.
`default_nettype none
module treadmill_status_frame_decoder_unit #(
    parameter int FRAME_MIN_BYTES = 17,
    parameter int SPEED_TABLE_ENTRIES = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  device_state,
    output logic        short_frame,
    output logic [7:0]  countdown,
    output logic [23:0] elapsed_ms,
    output logic [14:0] distance_centikm,
    output logic [14:0] calories,
    output logic [6:0]  speed_step,
    output logic [9:0]  real_speed_centikmh,
    output logic [14:0] steps,
    output logic [31:0] total_time_ms,
    output logic [31:0] total_distance_centikm,
    output logic [31:0] total_calories_steps
);
    import tsfd_pkg::*;

    localparam logic [4:0] POS_MAX = '1;

    logic        in_valid_reg;
    logic        req_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;

    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  cap_reg [CAPTURE_DEPTH];
    frame_bytes_t frame_view;
    decode_t     dec;

    dev_state_t  dev_reg, dev_next;
    logic        short_reg, short_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  cd_reg, cd_next;
    logic [23:0] elapsed_reg, elapsed_next;
    logic [14:0] dist_reg, dist_next;
    logic [14:0] cal_reg, cal_next;
    logic [14:0] steps_reg, steps_next;
    logic [6:0]  step_reg, step_next;
    logic [9:0]  real_reg, real_next;
    logic [31:0] sum_time_reg, sum_time_next;
    logic [31:0] sum_dist_reg, sum_dist_next;
    logic [15:0] sum_cal_reg, sum_cal_next;
    logic [15:0] sum_steps_reg, sum_steps_next;

    logic        s1_emits;
    logic        s1_block;
    logic        s1_go;
    logic        capture_en;
    logic [5:0]  count;
    logic        is_short;

    assign s1_emits = (req_reg == REQ_CLEAR) || end_reg;
    assign s1_block = in_valid_reg && s1_emits && out_valid_reg && out_stall;
    assign s1_go = in_valid_reg && !s1_block;
    assign in_stall = s1_block;
    assign capture_en = s1_go && (req_reg == REQ_BYTE) && (pos_reg < 5'(CAPTURE_DEPTH));
    assign count = {1'b0, pos_reg} + 6'd1;
    assign is_short = (count < 6'(FRAME_MIN_BYTES)) || (count < 6'(CAPTURE_DEPTH));

    always_comb
    begin
        for (int i = 0; i < CAPTURE_DEPTH; i++)
        begin
            frame_view[i] = (capture_en && (pos_reg == 5'(i))) ? byte_reg : cap_reg[i];
        end
    end

    tsfd_decode #(
        .SPEED_TABLE_ENTRIES(SPEED_TABLE_ENTRIES)
    ) u_decode (
        .frame (frame_view),
        .fields(dec)
    );

    always_comb
    begin
        pos_next = pos_reg;
        dev_next = dev_reg;
        short_next = short_reg;
        cd_next = cd_reg;
        elapsed_next = elapsed_reg;
        dist_next = dist_reg;
        cal_next = cal_reg;
        steps_next = steps_reg;
        step_next = step_reg;
        real_next = real_reg;
        sum_time_next = sum_time_reg;
        sum_dist_next = sum_dist_reg;
        sum_cal_next = sum_cal_reg;
        sum_steps_next = sum_steps_reg;
        if (s1_go)
        begin
            if (req_reg == REQ_CLEAR)
            begin
                short_next = 1'b0;
                sum_time_next = 32'(elapsed_reg);
                sum_dist_next = 32'(dist_reg);
                sum_cal_next = 16'(cal_reg);
                sum_steps_next = 16'(steps_reg);
            end
            else if (!end_reg)
            begin
                pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 5'd1;
            end
            else
            begin
                pos_next = 5'd0;
                short_next = is_short;
                if (!is_short)
                begin
                    dev_next = dec.state;
                    if (dec.state != DEV_UNKNOWN)
                    begin
                        cd_next = dec.countdown;
                        step_next = dec.speed_step;
                        real_next = dec.real_speed;
                        elapsed_next = dec.elapsed;
                        dist_next = dec.distance;
                        cal_next = dec.calories;
                        steps_next = dec.steps;
                        sum_time_next = track32(32'(dec.elapsed), 32'(elapsed_reg),
                                                sum_time_reg);
                        sum_dist_next = track32(32'(dec.distance), 32'(dist_reg),
                                                sum_dist_reg);
                        sum_cal_next = track16(16'(dec.calories), 16'(cal_reg), sum_cal_reg);
                        sum_steps_next = track16(16'(dec.steps), 16'(steps_reg),
                                                 sum_steps_reg);
                    end
                end
            end
        end
    end

    always_comb
    begin
        priority if (s1_go && s1_emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg <= 5'd0;
            dev_reg <= DEV_STOPPED;
            short_reg <= 1'b0;
            cd_reg <= 8'd0;
            elapsed_reg <= 24'd0;
            dist_reg <= 15'd0;
            cal_reg <= 15'd0;
            steps_reg <= 15'd0;
            step_reg <= 7'd0;
            real_reg <= 10'd0;
            sum_time_reg <= 32'd0;
            sum_dist_reg <= 32'd0;
            sum_cal_reg <= 16'd0;
            sum_steps_reg <= 16'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            pos_reg <= pos_next;
            dev_reg <= dev_next;
            short_reg <= short_next;
            cd_reg <= cd_next;
            elapsed_reg <= elapsed_next;
            dist_reg <= dist_next;
            cal_reg <= cal_next;
            steps_reg <= steps_next;
            step_reg <= step_next;
            real_reg <= real_next;
            sum_time_reg <= sum_time_next;
            sum_dist_reg <= sum_dist_next;
            sum_cal_reg <= sum_cal_next;
            sum_steps_reg <= sum_steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= req_type;
            byte_reg <= frame_byte;
            end_reg <= frame_end;
        end
        if (capture_en)
        begin
            cap_reg[pos_reg] <= byte_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign device_state = dev_reg;
    assign short_frame = short_reg;
    assign countdown = cd_reg;
    assign elapsed_ms = elapsed_reg;
    assign distance_centikm = dist_reg;
    assign calories = cal_reg;
    assign speed_step = step_reg;
    assign real_speed_centikmh = real_reg;
    assign steps = steps_reg;
    assign total_time_ms = sum_time_reg;
    assign total_distance_centikm = sum_dist_reg;
    assign total_calories_steps = {sum_cal_reg, sum_steps_reg};

endmodule
`default_nettype wire

/* rtl/core/tsfd_decode.sv */
// Field decode of one complete status frame: state, countdown, session values, speed.
// Depends on tsfd_pkg (frame layout, status codes, speed table builder).
`default_nettype none
module tsfd_decode #(
    parameter int SPEED_TABLE_ENTRIES = 9
) (
    input  tsfd_pkg::frame_bytes_t frame,
    output tsfd_pkg::decode_t      fields
);
    import tsfd_pkg::*;

    localparam speed_lut_t SPEED_LUT = build_speed_lut(SPEED_TABLE_ENTRIES);

    dev_state_t state;
    logic [6:0] step;

    always_comb
    begin
        unique case (frame[IDX_STATUS])
            STATUS_STOPPED:  state = DEV_STOPPED;
            STATUS_STARTING: state = DEV_STARTING;
            STATUS_RUNNING:  state = DEV_RUNNING;
            STATUS_PAUSED:   state = DEV_PAUSED;
            default:         state = DEV_UNKNOWN;
        endcase
    end

    assign step = (frame[IDX_SPEED] > 8'(SPEED_STEP_MAX)) ? 7'(SPEED_STEP_MAX)
                                                          : frame[IDX_SPEED][6:0];

    always_comb
    begin
        fields.state = state;
        fields.countdown = (state == DEV_STARTING) ? frame[IDX_COUNTDOWN] : 8'd0;
        fields.elapsed = 24'(frame[IDX_ELAPSED_SEC]) * MS_PER_SEC
                       + 24'(frame[IDX_ELAPSED_MIN]) * MS_PER_MIN;
        fields.distance = 15'(frame[IDX_DIST_HI]) * HI_BYTE_SCALE + 15'(frame[IDX_DIST_LO]);
        fields.calories = 15'(frame[IDX_CAL_HI]) * HI_BYTE_SCALE + 15'(frame[IDX_CAL_LO]);
        fields.steps = 15'(frame[IDX_STEPS_HI]) * HI_BYTE_SCALE + 15'(frame[IDX_STEPS_LO]);
        fields.speed_step = step;
        fields.real_speed = SPEED_LUT[step];
    end

endmodule
`default_nettype wire

/* rtl/core/tsfd_checker.sv */
// Port-level checks for the treadmill status frame decoder, bound to the top level.
// Depends on treadmill_status_frame_decoder_unit port names.
`default_nettype none
module tsfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  device_state,
    input logic [31:0] total_time_ms,
    input logic [31:0] total_distance_centikm,
    input logic [31:0] total_calories_steps
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(device_state) && $stable(total_time_ms))
        else $error("result word changed while stalled");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type |-> ##2 out_valid)
        else $error("clear request gave no result word");

    a_totals_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 !out_valid |-> $stable(total_time_ms)
            && $stable(total_distance_centikm) && $stable(total_calories_steps))
        else $error("totals changed without a result word");

endmodule

bind treadmill_status_frame_decoder_unit tsfd_checker u_tsfd_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .req_type              (req_type),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .device_state          (device_state),
    .total_time_ms         (total_time_ms),
    .total_distance_centikm(total_distance_centikm),
    .total_calories_steps  (total_calories_steps)
);
`default_nettype wire
